[rtl/core/ptrs_pkg.sv]
`timescale 1ns / 1ps
package ptrs_pkg;

	localparam int NumTasksDef = 8;
	localparam int MaxOut      = 8;
	localparam int CntW        = $clog2(MaxOut + 1);

	typedef enum logic [2:0] {
		REQ_TICK    = 3'd0,
		REQ_CREATE  = 3'd1,
		REQ_SUSPEND = 3'd2,
		REQ_RESUME  = 3'd3,
		REQ_DELETE  = 3'd4
	} req_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_FLUSH
	} state_t;

	typedef struct packed {
		logic tick_start;
		logic cmd_apply;
		logic step;
		logic flush;
	} ctrl_t;

	typedef struct packed {
		logic is_tick;
		logic out_free;
		logic need_push;
		logic last_slot;
	} stat_t;

endpackage

[rtl/core/ptrs_ctrl.sv]
`timescale 1ns / 1ps
module ptrs_ctrl (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           s_tvalid,
	output logic           s_tready,
	input  ptrs_pkg::stat_t stat,
	output ptrs_pkg::ctrl_t ctrl
);
	import ptrs_pkg::*;

	state_t state_q;
	state_t state_d;
	logic   accept;

	assign s_tready = (state_q == ST_IDLE) && stat.out_free;
	assign accept   = s_tvalid && s_tready;

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (accept && stat.is_tick) state_d = ST_SCAN;
			end
			ST_SCAN: begin
				if (ctrl.step && stat.last_slot) state_d = ST_FLUSH;
			end
			ST_FLUSH: begin
				if (stat.out_free) state_d = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		ctrl.tick_start = accept && stat.is_tick;
		ctrl.cmd_apply  = accept && !stat.is_tick;
		ctrl.step       = (state_q == ST_SCAN) && !(stat.need_push && !stat.out_free);
		ctrl.flush      = (state_q == ST_FLUSH) && stat.out_free;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

endmodule

[rtl/core/ptrs_dp.sv]
`timescale 1ns / 1ps
module ptrs_dp #(
	parameter int NUM_TASKS = ptrs_pkg::NumTasksDef
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic [2:0]     req_type,
	input  logic [2:0]     task_id,
	input  logic [15:0]    period,
	input  logic [7:0]     first_delay,
	input  logic           m_tready,
	output logic           m_tvalid,
	output logic           released,
	output logic [2:0]     task_index,
	output logic           accepted,
	output logic           last,
	input  ptrs_pkg::ctrl_t ctrl,
	output ptrs_pkg::stat_t stat
);
	import ptrs_pkg::*;

	localparam int SW = (NUM_TASKS > 1) ? $clog2(NUM_TASKS) : 1;

	logic [NUM_TASKS-1:0] valid_q;
	logic [NUM_TASKS-1:0] ready_q;
	logic [15:0]          per_mem [NUM_TASKS];
	logic [15:0]          cd_mem  [NUM_TASKS];
	logic [15:0]          per_s1;
	logic [15:0]          cd_s1;

	logic [SW-1:0]        idx_q;
	logic [SW-1:0]        rd_addr;
	logic [SW-1:0]        id_slot;
	logic [CntW-1:0]      n_q;
	logic                 pend_q;
	logic [2:0]           pend_idx_q;

	logic                 out_valid_q;
	logic                 out_rel_q;
	logic [2:0]           out_idx_q;
	logic                 out_acc_q;
	logic                 out_last_q;

	logic                 in_range;
	logic                 cmd_acc;
	logic                 hit;
	logic                 rel;
	logic                 capture;
	logic                 push;
	logic                 push_rel;
	logic [2:0]           push_idx;
	logic                 push_acc;
	logic                 push_last;

	assign id_slot  = SW'(task_id);
	assign in_range = 32'(task_id) < NUM_TASKS;
	assign rd_addr  = ctrl.tick_start ? '0 : (ctrl.step ? SW'(idx_q + 1'b1) : idx_q);

	always_comb begin
		cmd_acc = 1'b0;
		if (in_range) begin
			unique case (req_type)
				REQ_CREATE:  cmd_acc = !valid_q[id_slot];
				REQ_SUSPEND,
				REQ_RESUME,
				REQ_DELETE:  cmd_acc = 1'b1;
				default:     cmd_acc = 1'b0;
			endcase
		end
	end

	assign hit     = valid_q[idx_q] && ready_q[idx_q];
	assign rel     = hit && (cd_s1 == 16'd0);
	assign capture = rel && (n_q < CntW'(MaxOut));

	assign stat.is_tick   = (req_type == REQ_TICK);
	assign stat.out_free  = !out_valid_q || m_tready;
	assign stat.need_push = capture && pend_q;
	assign stat.last_slot = (32'(idx_q) == NUM_TASKS - 1);

	always_comb begin
		push      = 1'b0;
		push_rel  = 1'b0;
		push_idx  = '0;
		push_acc  = 1'b0;
		push_last = 1'b0;
		priority if (ctrl.cmd_apply) begin
			push      = 1'b1;
			push_acc  = cmd_acc;
			push_last = 1'b1;
		end else if (ctrl.step && stat.need_push) begin
			push      = 1'b1;
			push_rel  = 1'b1;
			push_idx  = pend_idx_q;
		end else if (ctrl.flush) begin
			push      = 1'b1;
			push_rel  = pend_q;
			push_idx  = pend_q ? pend_idx_q : 3'd0;
			push_last = 1'b1;
		end
	end

	// slot flags
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
			ready_q <= '0;
		end else if (ctrl.cmd_apply && in_range) begin
			unique case (req_type)
				REQ_CREATE: begin
					if (!valid_q[id_slot]) begin
						valid_q[id_slot] <= 1'b1;
						ready_q[id_slot] <= 1'b1;
					end
				end
				REQ_SUSPEND: ready_q[id_slot] <= 1'b0;
				REQ_RESUME:  ready_q[id_slot] <= 1'b1;
				REQ_DELETE:  valid_q[id_slot] <= 1'b0;
				default: ;
			endcase
		end
	end

	// period and countdown table
	always_ff @(posedge clk) begin
		if (ctrl.cmd_apply && in_range && (req_type == REQ_CREATE) && !valid_q[id_slot]) begin
			per_mem[id_slot] <= period;
			cd_mem[id_slot]  <= {8'd0, first_delay};
		end else if (ctrl.step && hit) begin
			cd_mem[idx_q] <= rel ? (per_s1 - 16'd1) : (cd_s1 - 16'd1);
		end
		per_s1 <= per_mem[rd_addr];
		cd_s1  <= cd_mem[rd_addr];
	end

	// scan position and held release
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q      <= '0;
			n_q        <= '0;
			pend_q     <= 1'b0;
			pend_idx_q <= '0;
		end else if (ctrl.tick_start) begin
			idx_q  <= '0;
			n_q    <= '0;
			pend_q <= 1'b0;
		end else if (ctrl.step) begin
			idx_q <= SW'(idx_q + 1'b1);
			if (capture) begin
				n_q        <= CntW'(n_q + 1'b1);
				pend_q     <= 1'b1;
				pend_idx_q <= 3'(idx_q);
			end
		end
	end

	// output beat register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (push) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			out_rel_q  <= push_rel;
			out_idx_q  <= push_idx;
			out_acc_q  <= push_acc;
			out_last_q <= push_last;
		end
	end

	assign m_tvalid   = out_valid_q;
	assign released   = out_rel_q;
	assign task_index = out_idx_q;
	assign accepted   = out_acc_q;
	assign last       = out_last_q;

endmodule

[rtl/core/periodic_task_release_scheduler_top.sv]
`timescale 1ns / 1ps
// Time-triggered task release scheduler with NUM_TASKS slots. A command beat (create,
// suspend, resume, delete) is applied and answered by one result beat. A tick beat walks
// the slot table one slot per cycle, except while a release beat waits for m_tready,
// through the registered read of the period and countdown table, and gives one beat per
// released slot (at most eight reported, tlast on the final one) or a single empty beat.
// Input tdata: req_type [2:0], task_id [5:3], period [21:6], first_delay [29:22].
// Output tdata: released [0], task_index [3:1], accepted [4]; tlast marks the final beat.
module periodic_task_release_scheduler_top #(
	parameter int NUM_TASKS = ptrs_pkg::NumTasksDef
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [31:0] s_tdata,  // req_type, task_id, period, first_delay
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [7:0]  m_tdata,  // released, task_index, accepted
	output logic        m_tlast
);
	import ptrs_pkg::*;

	ctrl_t      ctrl;
	stat_t      stat;
	logic       released;
	logic [2:0] task_index;
	logic       accepted;

	ptrs_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.stat     (stat),
		.ctrl     (ctrl)
	);

	ptrs_dp #(
		.NUM_TASKS (NUM_TASKS)
	) u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.req_type    (s_tdata[2:0]),
		.task_id     (s_tdata[5:3]),
		.period      (s_tdata[21:6]),
		.first_delay (s_tdata[29:22]),
		.m_tready    (m_tready),
		.m_tvalid    (m_tvalid),
		.released    (released),
		.task_index  (task_index),
		.accepted    (accepted),
		.last        (m_tlast),
		.ctrl        (ctrl),
		.stat        (stat)
	);

	assign m_tdata = {3'b000, accepted, task_index, released};

endmodule

[rtl/core/ptrs_checker.sv]
`timescale 1ns / 1ps
module ptrs_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        s_tvalid,
	input logic        s_tready,
	input logic [31:0] s_tdata,
	input logic        m_tvalid,
	input logic        m_tready,
	input logic [7:0]  m_tdata,
	input logic        m_tlast
);
	import ptrs_pkg::*;

	a_hold_valid: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid)
		else $error("output beat dropped while stalled");

	a_hold_data: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> $stable(m_tdata) && $stable(m_tlast))
		else $error("output beat changed while stalled");

	a_cmd_answer: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready && (s_tdata[2:0] != REQ_TICK) |=> m_tvalid && m_tlast
			&& !m_tdata[0])
		else $error("command not answered by a single beat");

	a_release_fields: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tdata[0] |-> !m_tdata[4])
		else $error("release beat carries accepted");

	a_empty_fields: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tdata[0] |-> (m_tdata[3:1] == 3'd0) && m_tlast)
		else $error("non-release beat malformed");

endmodule

bind periodic_task_release_scheduler_top ptrs_checker u_chk (.*);
